/* rtl/core/plas_pkg.sv */
// polyline arc-length sampler: shared types and constants
// depends on nothing; used by all modules
package plas_pkg;

  localparam int COORD_W = 32;
  localparam int LEN_W   = 40;
  localparam int FRAC_T  = 24;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef enum logic [1:0] {
    OP_CLEAR     = 2'd0,
    OP_APPEND    = 2'd1,
    OP_OVERWRITE = 2'd2,
    OP_SAMPLE    = 2'd3
  } plas_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } plas_status_t;

  // element 0 is x, 1 is y, 2 is z
  typedef logic [2:0][COORD_W-1:0] plas_point_t;

  typedef struct packed {
    plas_op_t          op;
    logic [5:0]        idx;
    plas_point_t       pt;
    logic [LEN_W-1:0]  arc_dist;
  } plas_cmd_t;

endpackage

/* rtl/core/plas_req_if.sv */
// request channel of the polyline sampler
// depends on nothing
interface plas_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [5:0]         point_index;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;
  logic signed [40:0] arc_distance;

  modport source (output valid, req_type, point_index, in_x, in_y, in_z, arc_distance,
                  input ready);
  modport sink   (input valid, req_type, point_index, in_x, in_y, in_z, arc_distance,
                  output ready);
endinterface

/* rtl/core/plas_rsp_if.sv */
// result channel of the polyline sampler
// depends on nothing
interface plas_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [1:0]         status;
  logic [6:0]         points_held;
  logic [39:0]        total_length;

  modport source (output valid, out_x, out_y, out_z, status, points_held, total_length,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_z, status, points_held, total_length,
                  output ready);
endinterface

/* rtl/core/plas_front.sv */
// front end: takes request words, decodes them and queues commands
// depends on plas_pkg and plas_req_if
module plas_front (
  input  logic                clk,
  input  logic                rst,
  plas_req_if.sink            req,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output plas_pkg::plas_cmd_t cmd
);

  plas_pkg::plas_cmd_t fifo [2];
  plas_pkg::plas_cmd_t dec;
  logic       wp, rp;
  logic [1:0] fill;
  logic       push, pop;

  assign req.ready = (fill != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = fifo[rp];

  // negative distance clamps to zero
  always_comb begin
    dec.op       = plas_pkg::plas_op_t'(req.req_type);
    dec.idx      = req.point_index;
    dec.pt       = {req.in_z, req.in_y, req.in_x};
    dec.arc_dist = req.arc_distance[40] ? '0 : req.arc_distance[39:0];
  end

  always_ff @(posedge clk) begin
    if (push) fifo[wp] <= dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd2) |=> (fill != 2'd0) && (fill == 2'd2 || $past(pop)))
    else $error("queue fill out of step");
`endif

endmodule

/* rtl/core/plas_back.sv */
// back end: point and length tables, sqrt and divide iterations, interpolation
// depends on plas_pkg and plas_rsp_if
module plas_back #(
  parameter int MAX_POINTS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  plas_pkg::plas_cmd_t cmd,
  plas_rsp_if.source          rsp
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int LW = plas_pkg::LEN_W;

  typedef enum logic [18:0] {
    S_IDLE   = 19'b0000000000000000001,
    S_REF_A  = 19'b0000000000000000010,
    S_REF_B  = 19'b0000000000000000100,
    S_REF_C  = 19'b0000000000000001000,
    S_SQ_MUL = 19'b0000000000000010000,
    S_SQ_ADD = 19'b0000000000000100000,
    S_ROOT   = 19'b0000000000001000000,
    S_ACC    = 19'b0000000000010000000,
    S_SCAN_A = 19'b0000000000100000000,
    S_SCAN_B = 19'b0000000001000000000,
    S_DIV    = 19'b0000000010000000000,
    S_LRD0   = 19'b0000000100000000000,
    S_LRD1   = 19'b0000001000000000000,
    S_LDIF   = 19'b0000010000000000000,
    S_LMUL   = 19'b0000100000000000000,
    S_LADD   = 19'b0001000000000000000,
    S_LAST   = 19'b0010000000000000000,
    S_LAST_B = 19'b0100000000000000000,
    S_FINISH = 19'b1000000000000000000
  } state_t;

  state_t state;
  logic [CW-1:0] count, ix, ix_m1, cnt_m1;
  logic [LW-1:0] arc_dist, seg_s, len, cum_prev, total;
  plas_pkg::plas_point_t pa, res;
  plas_pkg::plas_status_t status;
  logic signed [32:0] dv [3];
  logic [1:0] axis;
  logic [65:0] sum, rad;
  logic signed [67:0] prod;
  logic [35:0] rem_s;
  logic [32:0] root;
  logic [40:0] rem_d;
  logic [24:0] tq;
  logic [5:0] step;

  // tables
  plas_pkg::plas_point_t pts [MAX_POINTS];
  logic [LW-1:0] cum_mem [MAX_POINTS];
  plas_pkg::plas_point_t pt_q, pt_wd;
  logic [LW-1:0] cum_q, cum_wd;
  logic pt_we, pt_re, cum_we, cum_re;
  logic [AW-1:0] pt_wa, pt_ra, cum_wa, cum_ra;

  // start-of-command decode
  logic start, app_ok, ovw_ok;
  logic [CW-1:0] ovw_start;

  // arithmetic
  logic signed [32:0] dsel, dmag;
  logic signed [33:0] mul_a, mul_b;
  logic [35:0] rem_sh, trial;
  logic root_ge, div_ge;
  logic [40:0] r2;
  logic [LW:0] acc_sum;
  logic [LW-1:0] acc_sat;
  logic signed [67:0] biased, delta;
  logic [LW-1:0] f_len, f_off;

  assign cmd_ready = (state == S_IDLE);
  assign start     = cmd_valid && cmd_ready;
  assign ix_m1     = ix - CW'(1);
  assign cnt_m1    = count - CW'(1);
  assign app_ok    = (32'(count) < MAX_POINTS);
  assign ovw_ok    = (32'(cmd.idx) < 32'(count));
  assign ovw_start = (cmd.idx == 6'd0) ? CW'(1) : CW'(cmd.idx);

  // table ports
  always_comb begin
    pt_we  = start && ((cmd.op == plas_pkg::OP_APPEND && app_ok) ||
                       (cmd.op == plas_pkg::OP_OVERWRITE && ovw_ok));
    pt_wa  = (cmd.op == plas_pkg::OP_APPEND) ? count[AW-1:0] : AW'(cmd.idx);
    pt_wd  = cmd.pt;
    pt_re  = 1'b1;
    pt_ra  = ix[AW-1:0];
    unique case (state)
      S_REF_A, S_LRD0: pt_ra = ix_m1[AW-1:0];
      S_LAST:          pt_ra = cnt_m1[AW-1:0];
      S_REF_B, S_LRD1: pt_ra = ix[AW-1:0];
      default:         pt_re = 1'b0;
    endcase
    cum_re = (state == S_REF_A) || (state == S_SCAN_A);
    cum_ra = (state == S_REF_A) ? ix_m1[AW-1:0] : ix[AW-1:0];
    // first point always has zero length behind it
    cum_we = (start && cmd.op == plas_pkg::OP_APPEND && count == '0) || (state == S_ACC);
    cum_wa = (state == S_ACC) ? ix[AW-1:0] : '0;
    cum_wd = (state == S_ACC) ? acc_sat : '0;
  end

  always_ff @(posedge clk) begin
    if (pt_we) pts[pt_wa] <= pt_wd;
    if (pt_re) pt_q <= pts[pt_ra];
  end

  always_ff @(posedge clk) begin
    if (cum_we) cum_mem[cum_wa] <= cum_wd;
    if (cum_re) cum_q <= cum_mem[cum_ra];
  end

  // shared multiplier: squares of coordinate deltas or t times delta
  always_comb begin
    dsel = dv[axis];
    dmag = dsel[32] ? -dsel : dsel;
    if (state == S_LMUL) begin
      mul_a = {9'd0, tq};
      mul_b = {dsel[32], dsel};
    end else begin
      mul_a = {1'b0, dmag};
      mul_b = {1'b0, dmag};
    end
  end

  // one root bit per step
  assign rem_sh  = {rem_s[33:0], rad[65:64]};
  assign trial   = {1'b0, root, 2'b01};
  assign root_ge = (rem_sh >= trial);

  // one quotient bit per step
  assign div_ge = (rem_d >= {1'b0, len});
  assign r2     = div_ge ? (rem_d - {1'b0, len}) : rem_d;

  assign acc_sum = {1'b0, cum_prev} + {8'd0, root};
  assign acc_sat = acc_sum[LW] ? plas_pkg::LEN_MAX : acc_sum[LW-1:0];

  // truncation toward zero after dropping the fraction bits of t
  assign biased = prod + (prod[67] ? 68'sd16777215 : 68'sd0);
  assign delta  = biased >>> plas_pkg::FRAC_T;

  assign f_len = (cum_q > seg_s) ? (cum_q - seg_s) : LW'(1);
  assign f_off = (arc_dist > seg_s) ? (arc_dist - seg_s) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      total <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            res      <= '0;
            status   <= plas_pkg::ST_OK;
            arc_dist <= cmd.arc_dist;
            state    <= S_FINISH;
            unique case (cmd.op)
              plas_pkg::OP_CLEAR: begin
                count <= '0;
                total <= '0;
              end
              plas_pkg::OP_APPEND: begin
                if (!app_ok) begin
                  status <= plas_pkg::ST_FULL;
                end else begin
                  count <= count + CW'(1);
                  ix    <= count;
                  if (count == '0) total <= '0;
                  else state <= S_REF_A;
                end
              end
              plas_pkg::OP_OVERWRITE: begin
                if (!ovw_ok) begin
                  status <= plas_pkg::ST_BAD_INDEX;
                end else begin
                  ix <= ovw_start;
                  if (ovw_start < count) state <= S_REF_A;
                end
              end
              plas_pkg::OP_SAMPLE: begin
                ix    <= CW'(1);
                seg_s <= '0;
                if (count == CW'(1)) state <= S_LAST;
                else if (count != '0) state <= S_SCAN_A;
              end
              default: state <= S_FINISH;
            endcase
          end
        end
        S_REF_A: state <= S_REF_B;
        S_REF_B: begin
          pa       <= pt_q;
          cum_prev <= cum_q;
          state    <= S_REF_C;
        end
        S_REF_C, S_LDIF: begin
          for (int k = 0; k < 3; k++) begin
            dv[k] <= $signed({pt_q[k][31], pt_q[k]}) - $signed({pa[k][31], pa[k]});
          end
          axis  <= 2'd0;
          sum   <= '0;
          state <= (state == S_REF_C) ? S_SQ_MUL : S_LMUL;
        end
        S_SQ_MUL: begin
          prod  <= mul_a * mul_b;
          state <= S_SQ_ADD;
        end
        S_SQ_ADD: begin
          sum <= sum + prod[65:0];
          if (axis == 2'd2) begin
            rad   <= sum + prod[65:0];
            rem_s <= '0;
            root  <= '0;
            step  <= '0;
            state <= S_ROOT;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_SQ_MUL;
          end
        end
        S_ROOT: begin
          rem_s <= root_ge ? (rem_sh - trial) : rem_sh;
          root  <= {root[31:0], root_ge};
          rad   <= {rad[63:0], 2'b00};
          step  <= step + 6'd1;
          if (step == 6'd32) state <= S_ACC;
        end
        S_ACC: begin
          if (ix == cnt_m1) begin
            total <= acc_sat;
            state <= S_FINISH;
          end else begin
            ix    <= ix + CW'(1);
            state <= S_REF_A;
          end
        end
        S_SCAN_A: state <= S_SCAN_B;
        S_SCAN_B: begin
          if (arc_dist < cum_q) begin
            len   <= f_len;
            rem_d <= {1'b0, f_off};
            tq    <= '0;
            step  <= '0;
            state <= S_DIV;
          end else begin
            seg_s <= cum_q;
            ix    <= ix + CW'(1);
            state <= (ix == cnt_m1) ? S_LAST : S_SCAN_A;
          end
        end
        S_DIV: begin
          tq    <= {tq[23:0], div_ge};
          rem_d <= {r2[39:0], 1'b0};
          step  <= step + 6'd1;
          if (step == 6'd24) state <= S_LRD0;
        end
        S_LRD0: state <= S_LRD1;
        S_LRD1: begin
          pa    <= pt_q;
          state <= S_LDIF;
        end
        S_LMUL: begin
          prod  <= mul_a * mul_b;
          state <= S_LADD;
        end
        S_LADD: begin
          res[axis] <= pa[axis] + delta[31:0];
          if (axis == 2'd2) begin
            state <= S_FINISH;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_LMUL;
          end
        end
        S_LAST: state <= S_LAST_B;
        S_LAST_B: begin
          res   <= pt_q;
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!rsp.valid || rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_FINISH && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!rsp.valid || rsp.ready)) begin
      rsp.out_x        <= $signed(res[0]);
      rsp.out_y        <= $signed(res[1]);
      rsp.out_z        <= $signed(res[2]);
      rsp.status       <= status;
      rsp.points_held  <= 7'(count);
      rsp.total_length <= total;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= MAX_POINTS)
    else $error("point count above table size");

  a_total_short: assert property (@(posedge clk) disable iff (rst)
    (count <= CW'(1)) |-> (total == '0))
    else $error("length held for a table without segments");

  a_t_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && step == 6'd24) |=> (tq <= 25'h1000000))
    else $error("interpolation weight above one");

  a_ix_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_REF_A || state == S_SCAN_A) |-> (ix < count && ix != '0))
    else $error("segment index outside table");
`endif

endmodule

/* rtl/core/polyline_arc_length_sampler.sv */
// sample: scans segments in turn, then divides and interpolates on a hit, or returns the last point past the end
// append/overwrite: each recomputed segment runs through the 33-step square root
// throughput: one word at a time in the back end; front queue holds two more words
// reset: point count and total length cleared; point and length tables stay unwritten
// polyline sampler top: front decode queue feeding the table/arith back end
// depends on plas_pkg, plas_req_if, plas_rsp_if, plas_front, plas_back
module polyline_arc_length_sampler #(
  parameter int MAX_POINTS = 64
) (
  input logic        clk,
  input logic        rst,
  plas_req_if.sink   req,
  plas_rsp_if.source rsp
);

  // decoded command word between the halves
  logic                cmd_valid;
  logic                cmd_ready;
  plas_pkg::plas_cmd_t cmd;

  // front: clamps distance, queues two words so requests land while back is busy
  plas_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // back: tables, length refresh, segment scan, divide, lerp, result register
  plas_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp       (rsp)
  );

endmodule
